/* hdl/abmg_pkg.sv */
// Shared types and constants of the audio median, average, gain and VU block.
package abmg_pkg;

  localparam logic [2:0] REG_BLOCK_LEN = 3'd0;
  localparam logic [2:0] REG_WINDOW    = 3'd1;
  localparam logic [2:0] REG_MED_EN    = 3'd2;
  localparam logic [2:0] REG_AVG_EN    = 3'd3;
  localparam logic [2:0] REG_GAIN      = 3'd4;
  localparam logic [2:0] REG_VU_EN     = 3'd5;

  localparam logic [11:0] MID_CODE = 12'd2048;
  localparam logic [11:0] TOP_CODE = 12'd4095;

  // Settings that hold for one whole block.
  typedef struct packed {
    logic [4:0] w;
    logic       med;
    logic       avg;
    logic [7:0] gain;
    logic       vu;
  } blk_cfg_t;

endpackage

/* hdl/abmg_queue.sv */
// Small first-in first-out queue of fixed-width entries.
module abmg_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* hdl/abmg_div.sv */
// Restoring divider, one quotient bit per cycle.
module abmg_div #(
  parameter int DW = 24,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;

  assign trial    = {rem, quo[DW-1]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= VW'(trial - {1'b0, dvs});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= trial[VW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/abmg_front.sv */
// Front end: configuration registers, block position tracking and item tagging.
module abmg_front #(
  parameter int BLOCK_MAX  = 4096,
  parameter int WINDOW_MAX = 15,
  parameter int PW         = 13,
  parameter int SW         = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [12:0]         wr_data,
  input  logic                push,
  input  logic [11:0]         sample_in,
  input  logic                q_full,
  output logic                item_push,
  output logic [11:0]         item_x,
  output logic [PW-1:0]       item_p,
  output logic [SW-1:0]       item_slot,
  output logic                item_last,
  output logic [PW-1:0]       item_n,
  output abmg_pkg::blk_cfg_t  item_cfg
);
  import abmg_pkg::*;

  logic [12:0] block_len;
  logic [3:0]  window_size;
  logic        median_enable;
  logic        average_enable;
  logic [7:0]  gain_percent;
  logic        vu_enable;

  logic [PW-1:0] pos;
  logic [SW-1:0] slot;
  logic [PW-1:0] cur_n;
  blk_cfg_t      cur_cfg;

  logic [PW-1:0] n_new;
  logic [4:0]    w_new;
  logic          usable;
  blk_cfg_t      cfg_new;
  logic          accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len      <= 13'd256;
      window_size    <= 4'd5;
      median_enable  <= 1'b0;
      average_enable <= 1'b0;
      gain_percent   <= 8'd100;
      vu_enable      <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BLOCK_LEN: block_len      <= wr_data;
        REG_WINDOW:    window_size    <= wr_data[3:0];
        REG_MED_EN:    median_enable  <= wr_data[0];
        REG_AVG_EN:    average_enable <= wr_data[0];
        REG_GAIN:      gain_percent   <= wr_data[7:0];
        REG_VU_EN:     vu_enable      <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Settings as they would be latched by the first sample of a block.
  always_comb begin
    if (block_len == '0) begin
      n_new = PW'(1);
    end else if (32'(block_len) > 32'(BLOCK_MAX)) begin
      n_new = PW'(BLOCK_MAX);
    end else begin
      n_new = PW'(block_len);
    end
    w_new = (32'(window_size) > 32'(WINDOW_MAX)) ? 5'(WINDOW_MAX) : 5'(window_size);
    usable = (w_new >= 5'd2) && (32'(w_new) <= 32'(n_new));
    cfg_new.w    = w_new;
    cfg_new.med  = usable && median_enable;
    cfg_new.avg  = usable && average_enable;
    cfg_new.gain = gain_percent;
    cfg_new.vu   = vu_enable;
  end

  assign accept    = push && !q_full;
  assign item_push = accept;
  assign item_x    = sample_in;
  assign item_p    = pos;
  assign item_slot = slot;
  assign item_n    = (pos == '0) ? n_new : cur_n;
  assign item_cfg  = (pos == '0) ? cfg_new : cur_cfg;
  assign item_last = (pos == item_n - PW'(1));

  always_ff @(posedge clk) begin
    if (accept && pos == '0) begin
      cur_n   <= n_new;
      cur_cfg <= cfg_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      slot <= '0;
    end else if (accept) begin
      if (item_last) begin
        pos  <= '0;
        slot <= '0;
      end else begin
        pos  <= pos + PW'(1);
        slot <= (slot == SW'(WINDOW_MAX - 1)) ? '0 : slot + SW'(1);
      end
    end
  end

endmodule

/* hdl/abmg_back.sv */
// Back end: sliding median, sliding mean, gain, clamp and VU level per block.
module abmg_back #(
  parameter int BLOCK_MAX  = 4096,
  parameter int WINDOW_MAX = 15,
  parameter int PW         = 13,
  parameter int SW         = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_empty,
  output logic               item_pop,
  input  logic [11:0]        item_x,
  input  logic [PW-1:0]      item_p,
  input  logic [SW-1:0]      item_slot,
  input  logic               item_last,
  input  logic [PW-1:0]      item_n,
  input  abmg_pkg::blk_cfg_t item_cfg,
  input  logic               out_full,
  output logic               out_push,
  output logic [11:0]        out_sample,
  output logic               out_end,
  output logic [6:0]         out_level,
  output logic [6:0]         out_peak
);
  import abmg_pkg::*;

  localparam int MSW = 12 + $clog2(WINDOW_MAX + 1);
  localparam int ASW = $clog2(BLOCK_MAX) + 12;
  localparam int DW  = (ASW > MSW) ? ASW : MSW;
  localparam int VW  = (PW > 7) ? PW : 7;

  // ceil(2^26 / 100); exact for every gain product magnitude below 2^19.
  localparam logic [19:0] RECIP_100 = 20'd671089;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_QCHK   = 4'd1;
  localparam logic [3:0] S_MSWEEP = 4'd2;
  localparam logic [3:0] S_MWR    = 4'd3;
  localparam logic [3:0] S_RCHK   = 4'd4;
  localparam logic [3:0] S_SSWEEP = 4'd5;
  localparam logic [3:0] S_MDIV   = 4'd6;
  localparam logic [3:0] S_GMUL   = 4'd7;
  localparam logic [3:0] S_GSTART = 4'd8;
  localparam logic [3:0] S_GDIV   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;
  localparam logic [3:0] S_VDIV   = 4'd11;
  localparam logic [3:0] S_LVL    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;
  localparam logic [3:0] S_GCLAMP = 4'd14;

  logic [3:0] state;

  logic [11:0] raw  [WINDOW_MAX];
  logic [11:0] medh [WINDOW_MAX];

  logic [PW-1:0] cur_n;
  blk_cfg_t      cur_cfg;
  logic [PW-1:0] qpos, rpos, qtarget, rtarget;
  logic [SW-1:0] qslot, rslot, base, c;
  logic [11:0]   med_val, vval, yv;
  logic [MSW-1:0] mean_sum, sum_next;
  logic [ASW-1:0] abs_sum, abs_sum_new;
  logic [6:0]    level_hold, peak_hold, lvl;
  logic signed [21:0] prod;
  logic          neg, is_end;
  logic [17:0]   scaled;
  logic [18:0]   gmag;
  logic [38:0]   gscaled;
  logic [12:0]   gquo;

  logic          div_go, div_done;
  logic [DW-1:0] div_a, div_q;
  logic [VW-1:0] div_b;

  logic [4:0] h, e, la, hi, ei, lm_i;
  logic [PW:0] hx;
  logic [WINDOW_MAX-1:0] win_mask;
  logic [5:0] less_cnt, leq_cnt;
  logic       filt_q, filt_r;
  logic [11:0] yabs;

  function automatic logic [SW-1:0] base_of(input logic [SW-1:0] sl, input logic [4:0] hh);
    logic [SW:0] t;
    t = (SW+1)'(sl) + (SW+1)'(WINDOW_MAX) - (SW+1)'(hh);
    if (t >= (SW+1)'(WINDOW_MAX)) begin
      t = t - (SW+1)'(WINDOW_MAX);
    end
    return SW'(t);
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] sl);
    return (sl == SW'(WINDOW_MAX - 1)) ? '0 : sl + SW'(1);
  endfunction

  assign h    = cur_cfg.w >> 1;
  assign e    = (cur_cfg.w == '0) ? '0 : cur_cfg.w - 5'd1 - h;
  assign la   = cur_cfg.avg ? e : '0;
  assign hi   = item_cfg.w >> 1;
  assign ei   = (item_cfg.w == '0) ? '0 : item_cfg.w - 5'd1 - hi;
  assign lm_i = item_cfg.med ? ei : '0;
  assign hx   = (PW+1)'(h);

  // A position is filtered only where the whole window fits inside the block.
  assign filt_q = cur_cfg.med && ({1'b0, qpos} >= hx) && (({1'b0, qpos} + hx) < {1'b0, cur_n});
  assign filt_r = cur_cfg.avg && ({1'b0, rpos} >= hx) && (({1'b0, rpos} + hx) < {1'b0, cur_n});

  // Window membership of each history slot and the rank of the current candidate.
  always_comb begin
    logic [SW:0] off;
    less_cnt = '0;
    leq_cnt  = '0;
    for (int s = 0; s < WINDOW_MAX; s++) begin
      if (SW'(s) >= base) begin
        off = (SW+1)'(s) - (SW+1)'(base);
      end else begin
        off = (SW+1)'(s) + (SW+1)'(WINDOW_MAX) - (SW+1)'(base);
      end
      win_mask[s] = (6'(off) < 6'(cur_cfg.w));
    end
    for (int s = 0; s < WINDOW_MAX; s++) begin
      if (win_mask[s] && raw[s] < raw[c]) begin
        less_cnt = less_cnt + 6'd1;
      end
      if (win_mask[s] && raw[s] <= raw[c]) begin
        leq_cnt = leq_cnt + 6'd1;
      end
    end
  end

  assign sum_next    = mean_sum + (win_mask[c] ? MSW'(medh[c]) : '0);
  assign yabs        = (yv >= MID_CODE) ? yv - MID_CODE : MID_CODE - yv;
  assign abs_sum_new = abs_sum + ASW'(yabs);
  assign lvl         = (scaled[17:11] > 7'd100) ? 7'd100 : scaled[17:11];
  assign gscaled     = 39'(gmag) * 39'(RECIP_100);

  assign item_pop   = (state == S_IDLE) && !item_empty;
  assign out_push   = (state == S_OUT) && !out_full;
  assign out_sample = yv;
  assign out_end    = is_end;
  assign out_level  = level_hold;
  assign out_peak   = peak_hold;

  abmg_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (item_pop) begin
      raw[item_slot] <= item_x;
    end
    if (state == S_MWR) begin
      medh[qslot] <= med_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      qpos       <= '0;
      rpos       <= '0;
      qslot      <= '0;
      rslot      <= '0;
      abs_sum    <= '0;
      level_hold <= '0;
      peak_hold  <= '0;
      div_go     <= 1'b0;
    end else begin
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!item_empty) begin
            cur_n   <= item_n;
            cur_cfg <= item_cfg;
            if (item_p == '0) begin
              qpos  <= '0;
              rpos  <= '0;
              qslot <= '0;
              rslot <= '0;
            end
            if (item_last) begin
              qtarget <= item_n;
            end else if (item_p >= PW'(lm_i)) begin
              qtarget <= item_p - PW'(lm_i) + PW'(1);
            end else begin
              qtarget <= '0;
            end
            state <= S_QCHK;
          end
        end
        S_QCHK: begin
          if (qpos < qtarget) begin
            if (filt_q) begin
              base  <= base_of(qslot, h);
              c     <= '0;
              state <= S_MSWEEP;
            end else begin
              med_val <= raw[qslot];
              state   <= S_MWR;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_MSWEEP: begin
          if (win_mask[c] && (less_cnt <= 6'(h)) && (leq_cnt > 6'(h))) begin
            med_val <= raw[c];
          end
          c <= slot_inc(c);
          if (c == SW'(WINDOW_MAX - 1)) begin
            state <= S_MWR;
          end
        end
        S_MWR: begin
          if (qpos == cur_n - PW'(1)) begin
            rtarget <= cur_n;
          end else if (qpos >= PW'(la)) begin
            rtarget <= qpos - PW'(la) + PW'(1);
          end else begin
            rtarget <= '0;
          end
          qpos  <= qpos + PW'(1);
          qslot <= slot_inc(qslot);
          state <= S_RCHK;
        end
        S_RCHK: begin
          if (rpos < rtarget) begin
            if (filt_r) begin
              base     <= base_of(rslot, h);
              c        <= '0;
              mean_sum <= '0;
              state    <= S_SSWEEP;
            end else begin
              vval  <= medh[rslot];
              state <= S_GMUL;
            end
          end else begin
            state <= S_QCHK;
          end
        end
        S_SSWEEP: begin
          mean_sum <= sum_next;
          c        <= slot_inc(c);
          if (c == SW'(WINDOW_MAX - 1)) begin
            div_a  <= DW'(sum_next);
            div_b  <= VW'(cur_cfg.w);
            div_go <= 1'b1;
            state  <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            vval  <= div_q[11:0];
            state <= S_GMUL;
          end
        end
        S_GMUL: begin
          prod  <= ($signed({1'b0, vval}) - 13'sd2048) * $signed({1'b0, cur_cfg.gain});
          state <= S_GSTART;
        end
        S_GSTART: begin
          neg   <= prod[21];
          gmag  <= prod[21] ? 19'(-prod) : 19'(prod);
          state <= S_GDIV;
        end
        S_GDIV: begin
          gquo  <= gscaled[38:26];
          state <= S_GCLAMP;
        end
        S_GCLAMP: begin
          // The quotient is truncated toward zero, then moved back around midscale.
          if (neg) begin
            yv <= (gquo >= 13'd2048) ? '0 : MID_CODE - gquo[11:0];
          end else begin
            yv <= (gquo >= 13'd2048) ? TOP_CODE : MID_CODE + gquo[11:0];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          is_end <= (rpos == cur_n - PW'(1));
          if (rpos == cur_n - PW'(1)) begin
            if (cur_cfg.vu) begin
              div_a   <= DW'(abs_sum_new);
              div_b   <= VW'(cur_n);
              div_go  <= 1'b1;
              abs_sum <= '0;
              state   <= S_VDIV;
            end else begin
              abs_sum <= '0;
              state   <= S_OUT;
            end
          end else begin
            abs_sum <= abs_sum_new;
            state   <= S_OUT;
          end
        end
        S_VDIV: begin
          if (div_done) begin
            scaled <= 18'(div_q[11:0]) * 18'd100;
            state  <= S_LVL;
          end
        end
        S_LVL: begin
          level_hold <= lvl;
          if (lvl > peak_hold) begin
            peak_hold <= lvl;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_full) begin
            rpos  <= rpos + PW'(1);
            rslot <= slot_inc(rslot);
            state <= S_RCHK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/audio_block_median_average_gain_vu.sv */
// Top level of the block audio conditioner: median, mean, gain and VU meter.
//
//   channel   direction  request        payload
//   config    in         wr_en          wr_index, wr_data
//   samples   in         push / full    sample_in
//   results   out        pop / empty    sample_out, block_end, vu_level, vu_peak
//
// A filtered median adds a rank sweep over all WINDOW_MAX history slots, a filtered mean
// adds a sweep over those slots plus a divider pass, and the VU level at a block end adds
// a further divider pass. One input item yields up to WINDOW_MAX results at a block end.
// Reset clears positions, sums and holds; histories are never read before they are
// written in the current block. A two-entry queue on each side lets input and output
// stall on their own.
module audio_block_median_average_gain_vu #(
  parameter int BLOCK_MAX  = 4096,
  parameter int WINDOW_MAX = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [12:0] wr_data,
  input  logic        push,
  output logic        full,
  input  logic [11:0] sample_in,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] sample_out,
  output logic        block_end,
  output logic [6:0]  vu_level,
  output logic [6:0]  vu_peak
);
  import abmg_pkg::*;

  localparam int PW = $clog2(BLOCK_MAX + 1);
  localparam int SW = $clog2(WINDOW_MAX);
  localparam int IW = 12 + PW + SW + 1 + PW + $bits(blk_cfg_t);
  localparam int OW = 12 + 1 + 7 + 7;

  logic          f_push, f_last, b_last;
  logic [11:0]   f_x, b_x;
  logic [PW-1:0] f_p, f_n, b_p, b_n;
  logic [SW-1:0] f_slot, b_slot;
  blk_cfg_t      f_cfg, b_cfg;
  logic [IW-1:0] q_wdata, q_rdata;
  logic          q_full, q_empty, q_pop;

  logic          o_push, o_full, o_end;
  logic [11:0]   o_sample;
  logic [6:0]    o_level, o_peak;
  logic [OW-1:0] o_wdata, o_rdata;

  assign full = q_full;

  abmg_front #(
    .BLOCK_MAX(BLOCK_MAX), .WINDOW_MAX(WINDOW_MAX), .PW(PW), .SW(SW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .push      (push),
    .sample_in (sample_in),
    .q_full    (q_full),
    .item_push (f_push),
    .item_x    (f_x),
    .item_p    (f_p),
    .item_slot (f_slot),
    .item_last (f_last),
    .item_n    (f_n),
    .item_cfg  (f_cfg)
  );

  assign q_wdata = {f_x, f_p, f_slot, f_last, f_n, f_cfg};
  assign {b_x, b_p, b_slot, b_last, b_n, b_cfg} = q_rdata;

  abmg_queue #(.W(IW), .DEPTH(2)) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  abmg_back #(
    .BLOCK_MAX(BLOCK_MAX), .WINDOW_MAX(WINDOW_MAX), .PW(PW), .SW(SW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_empty (q_empty),
    .item_pop   (q_pop),
    .item_x     (b_x),
    .item_p     (b_p),
    .item_slot  (b_slot),
    .item_last  (b_last),
    .item_n     (b_n),
    .item_cfg   (b_cfg),
    .out_full   (o_full),
    .out_push   (o_push),
    .out_sample (o_sample),
    .out_end    (o_end),
    .out_level  (o_level),
    .out_peak   (o_peak)
  );

  assign o_wdata = {o_sample, o_end, o_level, o_peak};
  assign {sample_out, block_end, vu_level, vu_peak} = o_rdata;

  abmg_queue #(.W(OW), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata (o_wdata),
    .full  (o_full),
    .pop   (pop),
    .rdata (o_rdata),
    .empty (empty)
  );

endmodule

/* sim/testbench.sv */
// Testbench for the block audio conditioner: directed table, random phases, self-checking.
`timescale 1ns / 1ps

module testbench;
  import abmg_pkg::*;

  localparam int N_MAX = 4096;
  localparam int W_MAX = 15;
  localparam int SETTLE = 2000;
  localparam int STALL_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 280;
  localparam int TAIL_ITEMS = 24;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [11:0] smp;
    logic        last;
    logic [6:0]  level;
    logic [6:0]  peak;
  } vu_sample_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [12:0] value;
    logic [11:0] smp;
    bit          typed;
    vu_sample_t  want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [12:0] wr_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [11:0] sample_in = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [11:0] sample_out;
  logic        block_end;
  logic [6:0]  vu_level;
  logic [6:0]  vu_peak;

  audio_block_median_average_gain_vu DUT (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .push, .full, .sample_in,
    .empty, .pop, .sample_out, .block_end, .vu_level, .vu_peak
  );

  always #6 clk = ~clk;

  // Register shadows and conditioner state.
  int unsigned reg_len, reg_win, reg_med, reg_avg, reg_gain, reg_vu;
  int unsigned raw_hist [W_MAX];
  int unsigned med_hist [W_MAX];
  int unsigned blk_pos, abs_sum, level_hold, peak_hold;
  int unsigned blk_n, blk_w, blk_h, blk_e, blk_gain;
  bit blk_med, blk_avg, blk_vu;

  vu_sample_t pending_out [$];
  row_t stim_table [$];
  int errors = 0;
  bit sender_done = 0;
  int idle_cycles = 0;

  function automatic int unsigned slot(int unsigned i);
    return i % W_MAX;
  endfunction

  function automatic int unsigned window_value(bit from_median, int unsigned pos, bit mean);
    int unsigned buf_s [W_MAX];
    int unsigned base, sum, j, k, v;
    base = pos - blk_h;
    sum = 0;
    for (j = 0; j < blk_w; j++) begin
      v = from_median ? med_hist[slot(base + j)] : raw_hist[slot(base + j)];
      sum += v;
      k = j;
      while (k > 0 && buf_s[k - 1] > v) begin
        buf_s[k] = buf_s[k - 1];
        k--;
      end
      buf_s[k] = v;
    end
    return mean ? sum / blk_w : buf_s[blk_h];
  endfunction

  function automatic bit in_core(bit on, int unsigned pos);
    return on && pos >= blk_h && pos < blk_n - blk_h;
  endfunction

  task automatic emit_gained(int unsigned r, int unsigned v);
    int d, y;
    int unsigned mag, lvl;
    vu_sample_t o;
    d = int'(v) - 2048;
    y = d * int'(blk_gain) / 100 + 2048;
    if (y < 0) y = 0;
    if (y > 4095) y = 4095;
    mag = (y >= 2048) ? y - 2048 : 2048 - y;
    abs_sum += mag;
    o.last = (r == blk_n - 1);
    if (o.last) begin
      if (blk_vu) begin
        lvl = (abs_sum / blk_n) * 100 / 2048;
        if (lvl > 100) lvl = 100;
        level_hold = lvl;
        if (lvl > peak_hold) peak_hold = lvl;
      end
      abs_sum = 0;
    end
    o.smp = y[11:0];
    o.level = level_hold[6:0];
    o.peak = peak_hold[6:0];
    pending_out.push_back(o);
  endtask

  function automatic int unsigned mean_stage(int unsigned r);
    if (in_core(blk_avg, r)) return window_value(1, r, 1);
    return med_hist[slot(r)];
  endfunction

  task automatic median_stage(int unsigned q);
    int unsigned lag, r;
    lag = blk_avg ? blk_e : 0;
    med_hist[slot(q)] = in_core(blk_med, q) ? window_value(0, q, 0) : raw_hist[slot(q)];
    if (q >= lag) emit_gained(q - lag, mean_stage(q - lag));
    if (q == blk_n - 1)
      for (r = q - lag + 1; r < blk_n; r++) emit_gained(r, mean_stage(r));
  endtask

  task automatic predict_sample(logic [11:0] v);
    int unsigned p, lag, q;
    if (blk_pos == 0) begin
      // Settings are latched on the first sample of each block.
      blk_n = (reg_len == 0) ? 1 : reg_len;
      if (blk_n > N_MAX) blk_n = N_MAX;
      blk_w = (reg_win > W_MAX) ? W_MAX : reg_win;
      blk_h = blk_w / 2;
      blk_e = (blk_w >= 1) ? blk_w - 1 - blk_h : 0;
      blk_med = blk_w >= 2 && blk_w <= blk_n && reg_med != 0;
      blk_avg = blk_w >= 2 && blk_w <= blk_n && reg_avg != 0;
      blk_gain = reg_gain;
      blk_vu = reg_vu != 0;
    end
    p = blk_pos;
    raw_hist[slot(p)] = v;
    lag = blk_med ? blk_e : 0;
    if (p >= lag) median_stage(p - lag);
    if (p == blk_n - 1)
      for (q = p - lag + 1; q < blk_n; q++) median_stage(q);
    blk_pos = (p + 1 >= blk_n) ? 0 : p + 1;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Waits until every expected result is out and the block has had time to settle.
  task automatic wait_idle();
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BLOCK_LEN: reg_len = value;
      REG_WINDOW:    reg_win = value[3:0];
      REG_MED_EN:    reg_med = value[0];
      REG_AVG_EN:    reg_avg = value[0];
      REG_GAIN:      reg_gain = value[7:0];
      REG_VU_EN:     reg_vu = value[0];
      default: ;
    endcase
  endtask

  // Sends one sample, then idles for a random number of cycles.
  task automatic send_sample(logic [11:0] v, bit typed, vu_sample_t want);
    int gap;
    push <= 1'b1;
    sample_in <= v;
    do @(posedge clk); while (full);
    predict_sample(v);
    if (typed) pending_out[pending_out.size() - 1] = want;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drop_push();
    push <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [11:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'(2048 + $urandom_range(0, 64) - 32);
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic add_cfg(logic [2:0] idx, logic [12:0] value);
    row_t row;
    row = '{kind: ROW_CFG, default: '0};
    row.idx = idx;
    row.value = value;
    stim_table.push_back(row);
  endtask

  task automatic add_smp(logic [11:0] v, bit typed = 0, logic [11:0] s = 0, logic last = 0,
                         logic [6:0] level = 0, logic [6:0] peak = 0);
    row_t row;
    row = '{kind: ROW_SAMPLE, default: '0};
    row.smp = v;
    row.typed = typed;
    row.want = '{smp: s, last: last, level: level, peak: peak};
    stim_table.push_back(row);
  endtask

  initial begin
    int sent, count, blocks;
    vu_sample_t none;
    none = '{default: '0};
    reg_len = 256; reg_win = 5; reg_med = 0; reg_avg = 0; reg_gain = 100; reg_vu = 1;
    blk_pos = 0; abs_sum = 0; level_hold = 0; peak_hold = 0;
    blk_n = 1; blk_w = 0; blk_h = 0; blk_e = 0; blk_gain = 100;
    blk_med = 0; blk_avg = 0; blk_vu = 1;

    // One-sample blocks make every output readable by hand.
    add_cfg(REG_BLOCK_LEN, 13'd1);
    add_cfg(REG_WINDOW, 13'd0);
    add_smp(12'd0, 1, 12'd0, 1, 7'd100, 7'd100);
    add_smp(12'd4095, 1, 12'd4095, 1, 7'd99, 7'd100);
    add_smp(12'd2048, 1, 12'd2048, 1, 7'd0, 7'd100);
    add_cfg(REG_GAIN, 13'd0);
    add_smp(12'd4095, 1, 12'd2048, 1, 7'd0, 7'd100);
    add_cfg(REG_GAIN, 13'd255);
    add_smp(12'd0, 1, 12'd0, 1, 7'd100, 7'd100);
    add_smp(12'd4095, 1, 12'd4095, 1, 7'd99, 7'd100);
    add_cfg(REG_VU_EN, 13'd0);
    add_smp(12'd0, 1, 12'd0, 1, 7'd99, 7'd100);
    // Both filters on an impulse train.
    add_cfg(REG_VU_EN, 13'd1);
    add_cfg(REG_GAIN, 13'd100);
    add_cfg(REG_BLOCK_LEN, 13'd8);
    add_cfg(REG_WINDOW, 13'd3);
    add_cfg(REG_MED_EN, 13'd1);
    add_cfg(REG_AVG_EN, 13'd1);
    add_smp(12'd2048); add_smp(12'd2048); add_smp(12'd4095); add_smp(12'd2048);
    add_smp(12'd0); add_smp(12'd100); add_smp(12'd4000); add_smp(12'd2048);
    // Even window takes the upper median.
    add_cfg(REG_WINDOW, 13'd2);
    add_cfg(REG_BLOCK_LEN, 13'd4);
    add_smp(12'd10); add_smp(12'd3000); add_smp(12'd20); add_smp(12'd4095);
    // Window longer than the block bypasses both filters.
    add_cfg(REG_WINDOW, 13'd5);
    add_smp(12'd0); add_smp(12'd4095); add_smp(12'd1); add_smp(12'd4094);
    // Block length zero acts as one.
    add_cfg(REG_BLOCK_LEN, 13'd0);
    add_smp(12'd1234);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        if (push) drop_push();
        wait_idle();
        write_reg(stim_table[i].idx, stim_table[i].value);
      end else begin
        send_sample(stim_table[i].smp, stim_table[i].typed, stim_table[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (push) drop_push();
      wait_idle();
      case ($urandom_range(0, 9))
        0: write_reg(REG_BLOCK_LEN, 13'd0);
        1: write_reg(REG_BLOCK_LEN, 13'($urandom_range(25, 60)));
        default: write_reg(REG_BLOCK_LEN, 13'($urandom_range(1, 24)));
      endcase
      write_reg(REG_WINDOW, 13'($urandom_range(0, 15)));
      write_reg(REG_MED_EN, 13'($urandom_range(0, 1)));
      write_reg(REG_AVG_EN, 13'($urandom_range(0, 1)));
      write_reg(REG_GAIN, ($urandom_range(0, 5) == 0) ? 13'($urandom_range(0, 255))
                                                      : 13'($urandom_range(1, 200)));
      write_reg(REG_VU_EN, ($urandom_range(0, 3) == 0) ? 13'd0 : 13'd1);
      if (reg_len == 0) count = 1; else count = reg_len;
      blocks = $urandom_range(1, 3);
      count = count * blocks;
      // Now and then stop inside a block so the next settings wait for its end.
      if ($urandom_range(0, 4) == 0) count = count - $urandom_range(0, count - 1);
      repeat (count) begin
        send_sample(random_sample(), 0, none);
        sent++;
      end
    end

    // The start of a block at the top length, written with all bits set so it saturates.
    if (push) drop_push();
    wait_idle();
    while (blk_pos != 0) begin
      send_sample(random_sample(), 0, none);
    end
    if (push) drop_push();
    wait_idle();
    write_reg(REG_BLOCK_LEN, 13'h1FFF);
    write_reg(REG_WINDOW, 13'd15);
    write_reg(REG_MED_EN, 13'd1);
    write_reg(REG_AVG_EN, 13'd1);
    write_reg(REG_GAIN, 13'd200);
    write_reg(REG_VU_EN, 13'd1);
    write_reg(REG_UNUSED, 13'h0AAA);
    repeat (TAIL_ITEMS) send_sample(random_sample(), 0, none);
    push <= 1'b0;
    sender_done = 1;
  end

  // Result side: random stalls, then compare against the oldest expectation.
  initial begin
    int stall;
    vu_sample_t want;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (pending_out.size() == 0) begin
        report("unexpected result, sample_out", sample_out, -1);
      end else begin
        want = pending_out.pop_front();
        if (sample_out !== want.smp) report("sample_out", sample_out, want.smp);
        if (block_end !== want.last) report("block_end", block_end, want.last);
        if (vu_level !== want.level) report("vu_level", vu_level, want.level);
        if (vu_peak !== want.peak) report("vu_peak", vu_peak, want.peak);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || wr_en) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    wait (sender_done);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_out.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* audio_block_median_average_gain_vu.f */
hdl/abmg_pkg.sv
hdl/abmg_queue.sv
hdl/abmg_div.sv
hdl/abmg_front.sv
hdl/abmg_back.sv
hdl/audio_block_median_average_gain_vu.sv
sim/testbench.sv
